/* sv/cbc_pkg.sv */
`default_nettype none

package cbc_pkg;

	// Controller kind held in the configuration register.
	localparam logic [1:0] CART_NONE = 2'd0;
	localparam logic [1:0] CART_MBC1 = 2'd1;
	localparam logic [1:0] CART_MBC2 = 2'd2;

	// Access kind carried on the request side.
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Size of one cartridge RAM bank in bytes; a power of two.
	localparam int RAM_BANK_BYTES = 8192;
	localparam int RAM_OFS_W      = $clog2(RAM_BANK_BYTES);

	// Address window limits of the cartridge bus.
	localparam logic [15:0] ADDR_ENABLE_END = 16'h1FFF;
	localparam logic [15:0] ADDR_ROM0_END   = 16'h3FFF;
	localparam logic [15:0] ADDR_UPPER_END  = 16'h5FFF;
	localparam logic [15:0] ADDR_ROM1_END   = 16'h7FFF;
	localparam logic [15:0] ADDR_RAM_BASE   = 16'hA000;
	localparam logic [15:0] ADDR_RAM_END    = 16'hBFFF;
	localparam logic [15:0] ADDR_MBC2_RAM_END = 16'hA200;

	// Low nibble of a write that turns cartridge RAM on.
	localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

	typedef enum logic [2:0] {
		REGION_ROM_FIXED  = 3'd0,
		REGION_ROM_BANKED = 3'd1,
		REGION_CART_RAM   = 3'd2,
		REGION_OTHER      = 3'd3,
		REGION_CONTROL    = 3'd4
	} region_t;

	typedef struct packed {
		logic [6:0] rom_bank;
		logic [1:0] ram_bank;
		logic       ram_enable;
		logic       rom_banking_mode;
	} bank_state_t;

	typedef struct packed {
		logic       ram_enabled;
		logic [1:0] ram_bank_now;
		logic [6:0] rom_bank_now;
		logic       ram_write;
		logic [14:0] ram_address;
		logic [20:0] rom_address;
	} result_t;

endpackage

`default_nettype wire

/* sv/cartridge_bank_controller_core.sv */
`default_nettype none

// Cartridge bank controller core for MBC1 and MBC2 style cartridges.
// Bus requests enter on the s_* stream: s_tuser is the access kind (read or
// write), s_tdata carries the CPU address and the write byte. Each request
// produces exactly one result on the m_* stream: m_tuser gives the decoded
// region, m_tdata the physical ROM or cartridge RAM address, the RAM write
// permission and the banking registers as they stand after the request.
// The controller kind is written through the cfg_* channel, which is always
// ready; write it only while no request is in flight.
// A request is captured into an input register, decoded and mapped by short
// logic, and moves into the output register once that register is empty or
// being drained. One request per cycle is sustained while m_tready stays high;
// the single decode stage is the only path, and bank register updates from
// one request are visible to the very next one.
// When the receiver holds m_tready low, the result waits in the output
// register, the input register keeps the next request, and s_tready drops
// only once both are occupied. No request is lost or repeated.
// Reset puts ROM bank to 1, RAM bank to 0, RAM disabled, 16/8 banking mode,
// and the controller kind to none; both streams come out empty.
module cartridge_bank_controller_core
	import cbc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration: cfg_data is the controller kind.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_data,
	// Request stream.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // address[15:0], write_data[23:16]
	input  wire logic        s_tuser,  // op[0]
	// Result stream.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// rom_address[20:0], ram_address[35:21], ram_write[36], rom_bank_now[43:37],
	// ram_bank_now[45:44], ram_enabled[46], zero pad[47]
	output logic [47:0]      m_tdata,
	output logic [2:0]       m_tuser   // region[2:0]
);

	// Configuration register; the user must write it only while the core is idle, which the core does not enforce.
	logic [1:0] cart_type_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cart_type_q <= CART_NONE;
		end else if (cfg_valid) begin
			cart_type_q <= cfg_data;
		end
	end

	// Input register stage.
	logic        valid_s1;
	logic        op_s1;
	logic [15:0] addr_s1;
	logic [7:0]  data_s1;
	logic        advance;

	// The stage moves on whenever the output register is empty or being drained.
	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= s_tuser;
			addr_s1 <= s_tdata[15:0];
			data_s1 <= s_tdata[23:16];
		end
	end

	// Banking registers, updated as each request leaves the input stage.
	bank_state_t bank_q;
	bank_state_t bank_d;

	logic                 is_mbc1;
	logic                 is_mbc2;
	logic                 is_write;
	logic                 enable_hit;
	logic [4:0]           low_bits;
	logic [15:0]          ram_ofs_full;
	logic [RAM_OFS_W-1:0] ram_ofs;
	region_t              region;
	result_t              result;

	assign is_mbc1    = (cart_type_q == CART_MBC1);
	assign is_mbc2    = (cart_type_q == CART_MBC2);
	assign is_write   = (op_s1 == OP_WRITE);
	assign enable_hit = (data_s1[3:0] == RAM_ENABLE_KEY);
	// The MBC1 bank select never holds zero in its low five bits.
	assign low_bits   = (data_s1[4:0] == 5'd0) ? 5'd1 : data_s1[4:0];

	// Offset into the RAM window wraps at the bank size.
	assign ram_ofs_full = addr_s1 - ADDR_RAM_BASE;
	assign ram_ofs      = ram_ofs_full[RAM_OFS_W-1:0];

	// Next banking state: only writes to the control window change it.
	always_comb begin
		bank_d = bank_q;
		if (is_write && addr_s1 <= ADDR_ROM1_END) begin
			if (addr_s1 <= ADDR_ENABLE_END) begin
				// MBC2 ignores enable writes with address bit 8 set.
				if (is_mbc1 || (is_mbc2 && !addr_s1[8])) begin
					bank_d.ram_enable = enable_hit;
				end
			end else if (addr_s1 <= ADDR_ROM0_END) begin
				if (is_mbc1) begin
					bank_d.rom_bank = {bank_q.rom_bank[6:5], low_bits};
				end else if (is_mbc2) begin
					bank_d.rom_bank = {3'd0, data_s1[3:0]};
				end
			end else if (addr_s1 <= ADDR_UPPER_END) begin
				if (is_mbc1) begin
					if (bank_q.rom_banking_mode) begin
						bank_d.ram_bank = 2'd0;
						bank_d.rom_bank = {data_s1[1:0], bank_q.rom_bank[4:1],
							bank_q.rom_bank[0] | (bank_q.rom_bank[4:0] == 5'd0)};
					end else begin
						bank_d.ram_bank = data_s1[1:0];
					end
				end
			end else begin
				if (is_mbc1) begin
					if (data_s1[0]) begin
						bank_d.ram_bank         = 2'd0;
						bank_d.rom_banking_mode = 1'b0;
					end else begin
						bank_d.rom_banking_mode = 1'b1;
					end
				end
			end
		end
	end

	// Region decode and address mapping; reads see the banks as they stand.
	always_comb begin
		region             = REGION_OTHER;
		result             = '0;
		if (is_write && addr_s1 <= ADDR_ROM1_END) begin
			region = REGION_CONTROL;
		end else if (addr_s1 <= ADDR_ROM0_END) begin
			region             = REGION_ROM_FIXED;
			result.rom_address = {7'd0, addr_s1[13:0]};
		end else if (addr_s1 <= ADDR_ROM1_END) begin
			region             = REGION_ROM_BANKED;
			result.rom_address = {bank_q.rom_bank, addr_s1[13:0]};
		end else if (addr_s1 >= ADDR_RAM_BASE && addr_s1 <= ADDR_RAM_END) begin
			region             = REGION_CART_RAM;
			result.ram_address = 15'({bank_q.ram_bank, ram_ofs});
			result.ram_write   = is_write && bank_q.ram_enable &&
				(is_mbc1 || (is_mbc2 && addr_s1 < ADDR_MBC2_RAM_END));
		end
		result.rom_bank_now = bank_d.rom_bank;
		result.ram_bank_now = bank_d.ram_bank;
		result.ram_enabled  = bank_d.ram_enable;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q.rom_bank         <= 7'd1;
			bank_q.ram_bank         <= 2'd0;
			bank_q.ram_enable       <= 1'b0;
			bank_q.rom_banking_mode <= 1'b1;
		end else if (advance) begin
			bank_q <= bank_d;
		end
	end

	// Output register.
	logic        out_valid_q;
	result_t     result_q;
	region_t     region_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
			region_q <= region;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, result_q};
	assign m_tuser  = region_q;

endmodule

`default_nettype wire

/* tb/sv/tb_cartridge_bank_controller_core.sv */
`default_nettype none

// Self-checking bench for the cartridge bank controller core.
// Bus requests go in on the s_* stream and one result per request comes out on
// the m_* stream. A small scoreboard keeps its own copy of the banking registers
// and the controller kind. For every accepted request it works out the expected
// mapping and stores it. Each accepted result is then compared field by field
// with the oldest stored mapping.
module tb_cartridge_bank_controller_core;
	import cbc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// This limit is far above what the whole run needs, even under the heaviest
	// idling.
	localparam int CYCLE_LIMIT = 400000;

	// One expected mapping, in the same fields the block reports.
	typedef struct {
		region_t     region;
		logic [20:0] rom_address;
		logic [14:0] ram_address;
		logic        ram_write;
		logic [6:0]  rom_bank_now;
		logic [1:0]  ram_bank_now;
		logic        ram_enabled;
	} bus_mapping_t;

	// The scoreboard holds a shadow of the banking registers. It also holds the
	// queue of mappings that have not been seen on the result stream yet.
	class bank_map_scoreboard;
		logic [1:0]   cart_kind;
		logic [6:0]   rom_bank;
		logic [1:0]   ram_bank;
		logic         ram_on;
		logic         mode_16_8;
		bus_mapping_t pending_maps[$];
		int           errors;

		function new();
			cart_kind = CART_NONE;
			rom_bank  = 7'd1;
			ram_bank  = 2'd0;
			ram_on    = 1'b0;
			mode_16_8 = 1'b1;
			errors    = 0;
		endfunction

		function void set_cart_kind(logic [1:0] kind);
			cart_kind = kind;
		endfunction

		// Updates the shadow registers for one bus request and queues its mapping.
		function void note_request(logic op, logic [15:0] addr, logic [7:0] data);
			bus_mapping_t m;
			logic         mbc1;
			logic         mbc2;
			logic [4:0]   low_bits;
			int unsigned  ofs;
			mbc1 = (cart_kind == CART_MBC1);
			mbc2 = (cart_kind == CART_MBC2);
			m.region      = REGION_OTHER;
			m.rom_address = '0;
			m.ram_address = '0;
			m.ram_write   = 1'b0;
			if (op == OP_WRITE && addr <= ADDR_ROM1_END) begin
				m.region = REGION_CONTROL;
				if (addr <= ADDR_ENABLE_END) begin
					// MBC2 ignores the enable write when address bit 8 is set.
					if (mbc1 || (mbc2 && !addr[8]))
						ram_on = (data[3:0] == RAM_ENABLE_KEY);
				end else if (addr <= ADDR_ROM0_END) begin
					if (mbc1) begin
						// Bank 0 cannot be selected in the low five bits.
						low_bits = data[4:0];
						if (low_bits == 5'd0)
							low_bits = 5'd1;
						rom_bank = {rom_bank[6:5], low_bits};
					end else if (mbc2) begin
						rom_bank = {3'd0, data[3:0]};
					end
				end else if (addr <= ADDR_UPPER_END) begin
					if (mbc1) begin
						if (mode_16_8) begin
							ram_bank = 2'd0;
							rom_bank[6:5] = data[1:0];
							if (rom_bank[4:0] == 5'd0)
								rom_bank[0] = 1'b1;
						end else begin
							ram_bank = data[1:0];
						end
					end
				end else if (mbc1) begin
					if (data[0]) begin
						ram_bank  = 2'd0;
						mode_16_8 = 1'b0;
					end else begin
						mode_16_8 = 1'b1;
					end
				end
			end else if (addr <= ADDR_ROM0_END) begin
				m.region      = REGION_ROM_FIXED;
				m.rom_address = 21'(addr);
			end else if (addr <= ADDR_ROM1_END) begin
				// The full bank number is kept, so the address is not cut to 16 bits.
				m.region      = REGION_ROM_BANKED;
				m.rom_address = 21'(rom_bank) * 21'h4000 + 21'(addr - 16'h4000);
			end else if (addr >= ADDR_RAM_BASE && addr <= ADDR_RAM_END) begin
				ofs           = (int'(addr) - int'(ADDR_RAM_BASE)) % RAM_BANK_BYTES;
				m.region      = REGION_CART_RAM;
				m.ram_address = 15'(int'(ram_bank) * RAM_BANK_BYTES + ofs);
				m.ram_write   = (op == OP_WRITE) && ram_on &&
					(mbc1 || (mbc2 && addr < ADDR_MBC2_RAM_END));
			end
			m.rom_bank_now = rom_bank;
			m.ram_bank_now = ram_bank;
			m.ram_enabled  = ram_on;
			pending_maps.push_back(m);
		endfunction

		function void compare_field(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s expected 0x%0h actual 0x%0h", $time, field, want, got);
			end
		endfunction

		function void check_result(logic [2:0] region, logic [47:0] payload);
			bus_mapping_t m;
			if (pending_maps.size() == 0) begin
				errors++;
				$display("%0t: result with nothing outstanding, region 0x%0h data 0x%0h",
					$time, region, payload);
				return;
			end
			m = pending_maps.pop_front();
			compare_field("region", 32'(m.region), 32'(region));
			compare_field("rom_address", 32'(m.rom_address), 32'(payload[20:0]));
			compare_field("ram_address", 32'(m.ram_address), 32'(payload[35:21]));
			compare_field("ram_write", 32'(m.ram_write), 32'(payload[36]));
			compare_field("rom_bank_now", 32'(m.rom_bank_now), 32'(payload[43:37]));
			compare_field("ram_bank_now", 32'(m.ram_bank_now), 32'(payload[45:44]));
			compare_field("ram_enabled", 32'(m.ram_enabled), 32'(payload[46]));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic [2:0]  m_tuser;

	bank_map_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	int cycle_count;

	cartridge_bank_controller_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The receiver stalls at random. The share of stalled cycles is set per phase.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// The monitor samples on the edge, so it sees the values from before this
	// edge's updates. The result is checked before the new request is noted.
	// Latency keeps a result from ever meeting the request that caused it on
	// the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tuser, m_tdata);
			if (s_tvalid && s_tready)
				sb.note_request(s_tuser, s_tdata[15:0], s_tdata[23:16]);
			if (cfg_valid && cfg_ready)
				sb.set_cart_kind(cfg_data);
		end
	end

	// Watchdog in case the run hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: run did not finish within the cycle limit", $time);
			$display("tb_cartridge_bank_controller_core: done, errors");
			$finish;
		end
	end

	// Offers one request and returns on the edge that accepts it. s_tvalid stays
	// high after that edge. The next call either keeps it high or drops it for
	// an idle gap.
	task automatic send_request(input logic op, input logic [15:0] addr,
			input logic [7:0] data);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {data, addr};
		do @(posedge clk); while (!s_tready);
	endtask

	// Drops the request stream and waits until every mapping has come back.
	// It then lets the block settle before returning.
	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending_maps.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes the controller kind. The block is idle whenever this is called.
	task automatic write_cart_kind(input logic [1:0] kind);
		cfg_valid <= 1'b1;
		cfg_data  <= kind;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Random request shaped toward the interesting windows. Control writes get
	// a low nibble of 0xA often enough to toggle the RAM enable. RAM accesses
	// often fall below the MBC2 limit. Some requests use a fully random address
	// and access kind.
	task automatic send_random_request;
		int          pick;
		logic        op;
		logic [15:0] addr;
		logic [7:0]  data;
		pick = $urandom_range(0, 99);
		op   = 1'($urandom);
		addr = 16'($urandom);
		data = 8'($urandom);
		if ($urandom_range(0, 3) == 0)
			data[3:0] = RAM_ENABLE_KEY;
		if (pick < 35) begin
			op       = OP_WRITE;
			addr[15] = 1'b0;
		end else if (pick < 55) begin
			op       = OP_READ;
			addr[15] = 1'b0;
		end else if (pick < 85) begin
			addr[15:13] = 3'b101;
			if ($urandom_range(0, 1) == 0)
				addr[12:9] = 4'd0;
		end
		send_request(op, addr, data);
	endtask

	task automatic run_phase(input logic [1:0] kind, input int idle_pct,
			input int stall_pct, input int count);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		write_cart_kind(kind);
		repeat (count)
			send_random_request();
		drain();
	endtask

	initial begin
		sb             = new();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		cycle_count    <= 0;
		arst_n         <= 1'b0;
		cfg_valid      <= 1'b0;
		cfg_data       <= CART_NONE;
		s_tvalid       <= 1'b0;
		s_tdata        <= '0;
		s_tuser        <= OP_READ;
		m_tready       <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed MBC1 part. It covers the window edges, the bank-zero fix, the
		// top ROM bank at full width, both banking modes and the RAM enable.
		write_cart_kind(CART_MBC1);
		send_request(OP_READ,  16'h0000, 8'h00);
		send_request(OP_READ,  16'h3FFF, 8'hFF);
		send_request(OP_READ,  16'h4000, 8'h00);
		send_request(OP_READ,  16'h9FFF, 8'h00);
		send_request(OP_READ,  16'hC000, 8'h00);
		send_request(OP_READ,  16'hFFFF, 8'hFF);
		send_request(OP_WRITE, 16'h0000, 8'h0A);
		send_request(OP_WRITE, 16'hA000, 8'hFF);
		send_request(OP_WRITE, 16'h2000, 8'h00);
		send_request(OP_WRITE, 16'h3FFF, 8'hFF);
		send_request(OP_WRITE, 16'h4000, 8'h03);
		send_request(OP_READ,  16'h7FFF, 8'h00);
		send_request(OP_WRITE, 16'h6000, 8'h01);
		send_request(OP_WRITE, 16'h5FFF, 8'h03);
		send_request(OP_WRITE, 16'hBFFF, 8'h5A);
		send_request(OP_WRITE, 16'h7FFF, 8'h00);
		send_request(OP_WRITE, 16'h1FFF, 8'h00);
		send_request(OP_WRITE, 16'hBFFF, 8'h00);
		drain();

		// Directed MBC2 part. The enable write is skipped when address bit 8 is
		// set. RAM writes are limited to the low 512 bytes. Bank 0 is left
		// selected so that the MBC1 upper-bits write afterward sees low bits of
		// zero.
		write_cart_kind(CART_MBC2);
		send_request(OP_WRITE, 16'h0100, 8'h0A);
		send_request(OP_WRITE, 16'h0000, 8'h0A);
		send_request(OP_WRITE, 16'hA1FF, 8'h11);
		send_request(OP_WRITE, 16'hA200, 8'h22);
		send_request(OP_WRITE, 16'h2000, 8'hF0);
		send_request(OP_READ,  16'h4000, 8'h00);
		drain();
		write_cart_kind(CART_MBC1);
		send_request(OP_WRITE, 16'h4000, 8'h02);
		drain();

		// Random phases cycle through the controller kinds, including the unused
		// code. The idling patterns cover none, sender, receiver and both sides.
		run_phase(CART_MBC1, 0,  0,  225);
		run_phase(CART_MBC2, 60, 0,  225);
		run_phase(2'd3,      0,  60, 60);
		run_phase(CART_MBC1, 0,  60, 225);
		run_phase(CART_MBC2, 31, 31, 225);
		run_phase(CART_NONE, 60, 0,  60);
		run_phase(CART_MBC1, 31, 31, 225);
		run_phase(CART_MBC2, 0,  0,  225);

		if (sb.errors == 0) begin
			$display("tb_cartridge_bank_controller_core: done, clean");
		end else begin
			$display("tb_cartridge_bank_controller_core: done, errors");
		end
		$finish;
	end

	// A mapping still queued at the end would have been caught by drain, which
	// never returns with work outstanding. The watchdog reports that case.
endmodule

`default_nettype wire
